// File: rtl/sd_spi_command_engine_assert.svh
`ifndef SD_SPI_COMMAND_ENGINE_ASSERT_SVH
`define SD_SPI_COMMAND_ENGINE_ASSERT_SVH

// Check that a condition holds in the same cycle.
`define SDSCE_CHECK_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a cause is followed by an effect in the same cycle.
`define SDSCE_CHECK_IMPL(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cause) |-> (effect)) else $error(msg);

// Check that a cause is followed by an effect in the next cycle.
`define SDSCE_CHECK_NEXT(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) else $error(msg);

`endif

// File: rtl/sdsce_pkg.sv
package sdsce_pkg;

  localparam logic [1:0] OP_CMD        = 2'd0;
  localparam logic [1:0] OP_READY_WAIT = 2'd1;
  localparam logic [1:0] OP_RX         = 2'd2;

  localparam logic [1:0] KIND_TX    = 2'd0;
  localparam logic [1:0] KIND_R1    = 2'd1;
  localparam logic [1:0] KIND_READY = 2'd2;

  localparam logic [7:0] BYTE_FF       = 8'hFF;
  localparam logic [7:0] CMD_START     = 8'h40;
  localparam logic [7:0] CRC_POLY_LEFT = 8'h12;
  localparam logic [7:0] CRC_MASK      = 8'hFE;
  localparam logic [7:0] CRC_END_BIT   = 8'h01;
  localparam logic [5:0] CMD_STOP      = 6'd12;

  localparam logic [3:0] RETRY_LIMIT_RESET = 4'd8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Frame byte positions
  localparam logic [2:0] FB_CMD   = 3'd0;
  localparam logic [2:0] FB_ARG3  = 3'd1;
  localparam logic [2:0] FB_ARG2  = 3'd2;
  localparam logic [2:0] FB_ARG1  = 3'd3;
  localparam logic [2:0] FB_ARG0  = 3'd4;
  localparam logic [2:0] FB_CRC   = 3'd5;
  localparam logic [2:0] FB_STUFF = 3'd6;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_R1    = 2'd1,
    PH_READY = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic [7:0]  rx_byte;
  } sdsce_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last;
  } sdsce_out_t;

  // One unit of work for the back end: a whole command frame or one result.
  typedef struct packed {
    logic        is_frame;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
  } sdsce_job_t;

  typedef struct packed {
    logic full;
    logic head_valid;
  } sdsce_q_status_t;

  // CRC7 kept left-aligned in a byte; fold in one byte already xored in.
  function automatic logic [7:0] crc7_byte(input logic [7:0] value);
    logic [7:0] c;
    c = value;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY_LEFT;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/sdsce_front.sv
`include "sd_spi_command_engine_assert.svh"

module sdsce_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  sdsce_pkg::sdsce_in_t       in_item,
  input  logic                       cfg_wr_en,
  input  logic [3:0]                 cfg_wr_data,
  input  sdsce_pkg::sdsce_q_status_t q_status,
  output logic                       push,
  output sdsce_pkg::sdsce_job_t      push_job
);
  import sdsce_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic [3:0] retry_count;
  logic [3:0] retry_count_next;
  logic [3:0] r1_retry_limit;
  logic       accept;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_retry_limit <= RETRY_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      r1_retry_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      retry_count <= '0;
    end else begin
      phase       <= phase_next;
      retry_count <= retry_count_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    retry_count_next = retry_count;
    push             = 1'b0;
    push_job         = '0;
    push_job.kind      = KIND_TX;
    push_job.data_byte = BYTE_FF;
    if (accept) begin
      unique case (in_item.op)
        OP_CMD: begin
          push_job.is_frame  = 1'b1;
          push_job.cmd_index = in_item.cmd_index;
          push_job.argument  = in_item.argument;
          push             = 1'b1;
          phase_next       = PH_R1;
          retry_count_next = '0;
        end
        OP_READY_WAIT: begin
          push             = 1'b1;
          phase_next       = PH_READY;
          retry_count_next = '0;
        end
        OP_RX: begin
          unique case (phase)
            PH_R1: begin
              push = 1'b1;
              if (in_item.rx_byte == BYTE_FF && retry_count < r1_retry_limit) begin
                retry_count_next = retry_count + 4'd1;
              end else begin
                push_job.kind      = KIND_R1;
                push_job.data_byte = in_item.rx_byte;
                phase_next         = PH_IDLE;
                retry_count_next   = '0;
              end
            end
            PH_READY: begin
              push = 1'b1;
              // Keep polling until the card releases the line.
              if (in_item.rx_byte == BYTE_FF) begin
                push_job.kind = KIND_READY;
                phase_next    = PH_IDLE;
              end
            end
            PH_IDLE: begin
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  `SDSCE_CHECK_IMPL(a_idle_retry_clear, phase == PH_IDLE, retry_count == '0, "retry count left set while idle")

endmodule

// File: rtl/sdsce_queue.sv
`include "sd_spi_command_engine_assert.svh"

module sdsce_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  sdsce_pkg::sdsce_job_t      push_job,
  input  logic                       pop,
  output sdsce_pkg::sdsce_job_t      head_job,
  output sdsce_pkg::sdsce_q_status_t q_status
);
  import sdsce_pkg::*;

  sdsce_job_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_status.full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_status.head_valid = (count != '0);
  assign head_job            = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `SDSCE_CHECK_IMPL(a_no_push_full, push, !q_status.full, "push into full queue")
  `SDSCE_CHECK_IMPL(a_no_pop_empty, pop, q_status.head_valid, "pop from empty queue")

endmodule

// File: rtl/sdsce_back.sv
`include "sd_spi_command_engine_assert.svh"

module sdsce_back (
  input  logic                       clk,
  input  logic                       rst,
  input  sdsce_pkg::sdsce_q_status_t q_status,
  input  sdsce_pkg::sdsce_job_t      head_job,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output sdsce_pkg::sdsce_out_t      out_item
);
  import sdsce_pkg::*;

  logic [2:0] byte_idx;
  logic [7:0] crc;
  logic [7:0] crc_next;
  logic [7:0] cur_byte;
  logic       job_done;
  logic       load;

  assign load = q_status.head_valid && (!out_valid || !out_stall);
  assign pop  = load && job_done;

  always_comb begin
    cur_byte = head_job.data_byte;
    if (head_job.is_frame) begin
      unique case (byte_idx)
        FB_CMD:   cur_byte = CMD_START | {2'b00, head_job.cmd_index};
        FB_ARG3:  cur_byte = head_job.argument[31:24];
        FB_ARG2:  cur_byte = head_job.argument[23:16];
        FB_ARG1:  cur_byte = head_job.argument[15:8];
        FB_ARG0:  cur_byte = head_job.argument[7:0];
        FB_CRC:   cur_byte = (crc & CRC_MASK) | CRC_END_BIT;
        FB_STUFF: cur_byte = BYTE_FF;
        default:  cur_byte = BYTE_FF;
      endcase
    end
  end

  // Fold each header byte into the CRC as it goes out.
  assign crc_next = crc7_byte(((byte_idx == FB_CMD) ? 8'h00 : crc) ^ cur_byte);

  assign job_done = !head_job.is_frame
                 || (byte_idx == FB_CRC && head_job.cmd_index != CMD_STOP)
                 || (byte_idx == FB_STUFF);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_idx  <= FB_CMD;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        byte_idx  <= job_done ? FB_CMD : byte_idx + 3'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item.kind      <= head_job.kind;
      out_item.data_byte <= cur_byte;
      out_item.last      <= job_done;
      if (byte_idx <= FB_ARG0) begin
        crc <= crc_next;
      end
    end
  end

  `SDSCE_CHECK_IMPL(a_frame_held, byte_idx != FB_CMD, q_status.head_valid && head_job.is_frame, "frame left mid-way")
  `SDSCE_CHECK_NOW(a_idx_range, byte_idx <= FB_STUFF, "frame byte index out of range")
  `SDSCE_CHECK_NEXT(a_load_shows, load, out_valid, "loaded byte not presented")

endmodule

// File: rtl/sd_spi_command_engine.sv
// SD card SPI-mode command engine, host side. An issue-command item yields
// its frame as 6 transmit bytes (7 for CMD12, which adds a stuff byte) at one
// byte per cycle while the output is not stalled; every other item yields at
// most one result. The front end updates the R1/ready-wait state and accepts
// an item each cycle while its 2-entry job queue has room; the frame
// serializer in the back end sets the sustained rate, folding the CRC7 in one
// byte per cycle as the header goes out. Received bytes while idle and op code
// 3 are taken and give no result. The retry limit (reset 8) is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while the block is idle,
// as the block itself does not enforce this.
module sd_spi_command_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sdsce_pkg::sdsce_in_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sdsce_pkg::sdsce_out_t out_item,
  input  logic                  cfg_wr_en,
  input  logic [3:0]            cfg_wr_data
);
  import sdsce_pkg::*;

  sdsce_q_status_t q_status;
  sdsce_job_t      push_job;
  sdsce_job_t      head_job;
  logic            push;
  logic            pop;

  sdsce_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_status    (q_status),
    .push        (push),
    .push_job    (push_job)
  );

  sdsce_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_status (q_status)
  );

  sdsce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .head_job  (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
